@@ design/amgs_pkg.sv @@
// Shared types and constants for the adjacency matrix graph store.
package amgs_pkg;

    localparam int VCOUNT_BITS    = 5;
    localparam int VCOUNT_RESET   = 16;
    localparam int VERTEX_BITS    = 4;
    localparam int REACH_VERTICES = 2 ** VERTEX_BITS;
    localparam int NEIGHBOR_BITS  = 5;
    localparam int COUNT_BITS     = 9;
    localparam int WEIGHT_IN_BITS = 16;
    localparam int MARK_IN_BITS   = 8;
    localparam int MARK_OUT_BITS  = 8;

    typedef enum logic [2:0] {
        OP_SET_EDGE   = 3'd0,
        OP_DEL_EDGE   = 3'd1,
        OP_TEST_EDGE  = 3'd2,
        OP_FIRST_NBR  = 3'd3,
        OP_NEXT_NBR   = 3'd4,
        OP_READ_MARK  = 3'd5,
        OP_WRITE_MARK = 3'd6,
        OP_READ_COUNT = 3'd7
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        op_t                              kind;
        logic [VERTEX_BITS-1:0]           from_vertex;
        logic [VERTEX_BITS-1:0]           to_vertex;
        logic signed [WEIGHT_IN_BITS-1:0] weight;
        logic [MARK_IN_BITS-1:0]          mark_value;
    } req_t;

    typedef struct packed {
        logic                     edge_present;
        logic [NEIGHBOR_BITS-1:0] neighbor;
        logic [MARK_OUT_BITS-1:0] mark_out;
        logic [COUNT_BITS-1:0]    edge_count;
        logic                     bad_vertex;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

endpackage

@@ design/amgs_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module amgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/amgs_ctrl.sv @@
// Controller state machine sequencing each request through load and commit.
module amgs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output amgs_pkg::cmd_t cmd
);

    import amgs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result is committed only once the output register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

@@ design/amgs_dp.sv @@
// Datapath: weight memory, presence bitmap, marks, edge total and response register.
module amgs_dp #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16,
    parameter int MARK_BITS    = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  amgs_pkg::cmd_t                       cmd,
    input  amgs_pkg::req_t                       req,
    input  logic                                 cfg_valid,
    input  logic [amgs_pkg::VCOUNT_BITS-1:0]     cfg_data,
    output amgs_pkg::rsp_t                       rsp
);

    import amgs_pkg::*;

    localparam int RV    = (MAX_VERTICES < REACH_VERTICES) ? MAX_VERTICES : REACH_VERTICES;
    localparam int VW    = $clog2(RV);
    localparam int DEPTH = RV * (2 ** VW);

    req_t                   req_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic [VCOUNT_BITS-1:0] vc_reg;
    logic [COUNT_BITS-1:0]  total_reg;
    logic [COUNT_BITS-1:0]  total_next;
    logic [RV-1:0]          pres_reg [RV];
    logic [MARK_BITS-1:0]   mark_reg [RV];

    logic [VCOUNT_BITS-1:0] n_eff;
    logic [VW-1:0]          a_idx;
    logic [VW-1:0]          b_idx;
    logic                   a_ok;
    logic                   b_ok;
    logic                   ab_ok;
    logic                   edge_write;
    logic                   mark_write;
    logic [WEIGHT_BITS-1:0] wt;
    logic [WEIGHT_BITS-1:0] new_wt;
    logic                   new_present;
    logic                   old_present;
    logic [RV-1:0]          row;
    logic [VCOUNT_BITS-1:0] start;
    logic [VCOUNT_BITS-1:0] scan_nb;
    logic [WEIGHT_BITS-1:0] ram_rdata;

    always_comb
    begin
        if (vc_reg == '0)
        begin
            n_eff = VCOUNT_BITS'(1);
        end
        else if (int'(vc_reg) > MAX_VERTICES)
        begin
            n_eff = VCOUNT_BITS'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vc_reg;
        end
    end

    assign a_idx = req_reg.from_vertex[VW-1:0];
    assign b_idx = req_reg.to_vertex[VW-1:0];
    assign a_ok  = {1'b0, req_reg.from_vertex} < n_eff;
    assign b_ok  = {1'b0, req_reg.to_vertex} < n_eff;
    assign ab_ok = a_ok && b_ok;

    assign wt          = WEIGHT_BITS'($unsigned(req_reg.weight));
    assign new_wt      = (req_reg.kind == OP_SET_EDGE) ? wt : '0;
    assign new_present = new_wt != '0;
    assign old_present = ab_ok ? pres_reg[a_idx][b_idx] : 1'b0;
    assign edge_write  = cmd.commit && ab_ok &&
                         (req_reg.kind == OP_SET_EDGE || req_reg.kind == OP_DEL_EDGE);
    assign mark_write  = cmd.commit && a_ok && (req_reg.kind == OP_WRITE_MARK);

    amgs_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (edge_write),
        .waddr ({a_idx, b_idx}),
        .wdata (new_wt),
        .re    (cmd.load),
        .raddr ({req.from_vertex[VW-1:0], req.to_vertex[VW-1:0]}),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        total_next = total_reg;
        if (edge_write)
        begin
            if (!old_present && new_present)
            begin
                total_next = total_reg + COUNT_BITS'(1);
            end
            else if (old_present && !new_present)
            begin
                total_next = total_reg - COUNT_BITS'(1);
            end
        end
    end

    // Lowest set bit of the row at or above the start column and below the count.
    always_comb
    begin
        row     = a_ok ? pres_reg[a_idx] : '0;
        start   = (req_reg.kind == OP_FIRST_NBR) ? '0
                                                 : {1'b0, req_reg.to_vertex} + VCOUNT_BITS'(1);
        scan_nb = n_eff;
        for (int i = RV - 1; i >= 0; i--)
        begin
            if (row[i] && (VCOUNT_BITS'(i) >= start) && (VCOUNT_BITS'(i) < n_eff))
            begin
                scan_nb = VCOUNT_BITS'(i);
            end
        end
    end

    always_comb
    begin
        rsp_next            = '0;
        rsp_next.edge_count = total_next;
        case (req_reg.kind)
            OP_SET_EDGE, OP_DEL_EDGE:
            begin
                rsp_next.bad_vertex = !ab_ok;
            end
            OP_TEST_EDGE:
            begin
                rsp_next.bad_vertex   = !ab_ok;
                rsp_next.edge_present = old_present && (ram_rdata != '0);
            end
            OP_FIRST_NBR:
            begin
                rsp_next.bad_vertex = !a_ok;
                rsp_next.neighbor   = a_ok ? scan_nb : n_eff;
            end
            OP_NEXT_NBR:
            begin
                rsp_next.bad_vertex = !ab_ok;
                rsp_next.neighbor   = ab_ok ? scan_nb : n_eff;
            end
            OP_READ_MARK:
            begin
                rsp_next.bad_vertex = !a_ok;
                rsp_next.mark_out   = a_ok ? MARK_OUT_BITS'(mark_reg[a_idx]) : '0;
            end
            OP_WRITE_MARK:
            begin
                rsp_next.bad_vertex = !a_ok;
            end
            default:
            begin
                rsp_next.bad_vertex = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg    <= VCOUNT_BITS'(VCOUNT_RESET);
            total_reg <= '0;
            for (int r = 0; r < RV; r++)
            begin
                pres_reg[r] <= '0;
                mark_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                vc_reg <= cfg_data;
            end
            total_reg <= total_next;
            if (edge_write)
            begin
                pres_reg[a_idx][b_idx] <= new_present;
            end
            if (mark_write)
            begin
                mark_reg[a_idx] <= MARK_BITS'(req_reg.mark_value);
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ design/adjacency_matrix_graph_store.sv @@
// Top level of the adjacency matrix graph store: controller, datapath and checks.
//
//   Channel  Handshake              Payload
//   req      req_valid/req_ready    req  (kind, from_vertex, to_vertex, weight, mark_value)
//   rsp      rsp_valid/rsp_ready    rsp  (edge_present, neighbor, mark_out, edge_count, bad_vertex)
//   cfg      cfg_valid/cfg_ready    cfg_data (vertex_count)
//
// Each request is first registered while the weight memory is read, then evaluated
// against the presence bitmap and committed. The next request is taken in the
// following cycle while the previous response waits in the output register.
// A response stalled by rsp_ready holds the commit step of the next request.
// Reset clears the presence bitmap, marks and edge total at once; no clearing pass.
module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16,
    parameter int MARK_BITS    = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  amgs_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output amgs_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [amgs_pkg::VCOUNT_BITS-1:0] cfg_data
);

    import amgs_pkg::*;

    localparam int RV        = (MAX_VERTICES < REACH_VERTICES) ? MAX_VERTICES : REACH_VERTICES;
    localparam int MAX_EDGES = RV * RV;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    amgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    amgs_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .MARK_BITS    (MARK_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is being processed");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.edge_count) <= MAX_EDGES))
        else $error("edge total exceeds the matrix size");

    a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.edge_present |-> !rsp.bad_vertex)
        else $error("edge reported present for an invalid vertex");

    a_mark_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.mark_out != '0) |-> !rsp.bad_vertex)
        else $error("mark returned for an invalid vertex");

endmodule

@@ test/adjacency_matrix_graph_store_tb.sv @@
// Self-checking testbench for the adjacency matrix graph store: directed table, full matrix fill, then random requests.
module adjacency_matrix_graph_store_tb;
    import amgs_pkg::*;

    typedef struct packed {
        logic       cfg_write;
        logic [4:0] cfg_value;
        logic       typed;
        req_t       r;
        rsp_t       want;
    } plan_row_t;

    localparam int DIRECTED_ROWS = 30;
    localparam int PHASES = 8;
    localparam int PHASE_REQUESTS = 105;

    localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 5'd0, 1'b1, '{OP_READ_COUNT, 4'd0, 4'd0, 16'h0000, 8'h00},
            '{1'b0, 5'd0, 8'd0, 9'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b1, '{OP_FIRST_NBR, 4'd0, 4'd0, 16'h0000, 8'h00},
            '{1'b0, 5'd16, 8'd0, 9'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b1, '{OP_READ_MARK, 4'd15, 4'd0, 16'h0000, 8'h00},
            '{1'b0, 5'd0, 8'd0, 9'd0, 1'b0}},
        '{1'b0, 5'd0, 1'b1, '{OP_SET_EDGE, 4'd0, 4'd15, 16'h8000, 8'h00},
            '{1'b0, 5'd0, 8'd0, 9'd1, 1'b0}},
        '{1'b0, 5'd0, 1'b1, '{OP_SET_EDGE, 4'd15, 4'd0, 16'h7FFF, 8'hFF},
            '{1'b0, 5'd0, 8'd0, 9'd2, 1'b0}},
        '{1'b0, 5'd0, 1'b1, '{OP_SET_EDGE, 4'd0, 4'd15, 16'h0005, 8'h00},
            '{1'b0, 5'd0, 8'd0, 9'd2, 1'b0}},
        '{1'b0, 5'd0, 1'b1, '{OP_SET_EDGE, 4'd3, 4'd4, 16'h0000, 8'h00},
            '{1'b0, 5'd0, 8'd0, 9'd2, 1'b0}},
        '{1'b0, 5'd0, 1'b1, '{OP_DEL_EDGE, 4'd15, 4'd0, 16'h0000, 8'h00},
            '{1'b0, 5'd0, 8'd0, 9'd1, 1'b0}},
        '{1'b0, 5'd0, 1'b1, '{OP_DEL_EDGE, 4'd7, 4'd7, 16'h0000, 8'h00},
            '{1'b0, 5'd0, 8'd0, 9'd1, 1'b0}},
        '{1'b0, 5'd0, 1'b0, '{OP_SET_EDGE, 4'd0, 4'd3, 16'hFFFF, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_TEST_EDGE, 4'd0, 4'd3, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_NEXT_NBR, 4'd0, 4'd3, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_NEXT_NBR, 4'd0, 4'd15, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_WRITE_MARK, 4'd15, 4'd0, 16'h0000, 8'hFF}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_READ_MARK, 4'd15, 4'd0, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_SET_EDGE, 4'd0, 4'd15, 16'h0000, 8'h00}, '0},
        '{1'b1, 5'd4, 1'b0, '0, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_SET_EDGE, 4'd4, 4'd0, 16'h0007, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_NEXT_NBR, 4'd0, 4'd0, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_NEXT_NBR, 4'd0, 4'd3, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_FIRST_NBR, 4'd15, 4'd0, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_READ_MARK, 4'd4, 4'd0, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_WRITE_MARK, 4'd9, 4'd0, 16'h0000, 8'h5A}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_NEXT_NBR, 4'd1, 4'd4, 16'h0000, 8'h00}, '0},
        '{1'b1, 5'd0, 1'b0, '0, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_FIRST_NBR, 4'd0, 4'd0, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_TEST_EDGE, 4'd0, 4'd1, 16'h0000, 8'h00}, '0},
        '{1'b1, 5'd31, 1'b0, '0, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_FIRST_NBR, 4'd15, 4'd0, 16'h0000, 8'h00}, '0},
        '{1'b0, 5'd0, 1'b0, '{OP_READ_COUNT, 4'd3, 4'd9, 16'h0000, 8'h00}, '0}
    };

    localparam logic [4:0] PHASE_VCOUNT [PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd9, 5'd31, 5'd2, 5'd17, 5'd16
    };

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [VCOUNT_BITS-1:0] cfg_data = '0;

    logic [WEIGHT_IN_BITS-1:0] weight_matrix [REACH_VERTICES][REACH_VERTICES];
    logic [MARK_OUT_BITS-1:0] vertex_marks [REACH_VERTICES];
    int unsigned edge_total;
    logic [VCOUNT_BITS-1:0] vertex_count;

    rsp_t pending_rsp [$];
    logic no_idle = 1'b0;
    int errors = 0;
    int requests_sent = 0;
    int responses_seen = 0;
    int cfg_writes = 0;

    adjacency_matrix_graph_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int active_vertices();
        if (vertex_count == 0)
            return 1;
        if (vertex_count > REACH_VERTICES)
            return REACH_VERTICES;
        return int'(vertex_count);
    endfunction

    function automatic int scan_neighbours(input int row, input int start, input int n);
        for (int i = start; i < n; i++)
        begin
            if (weight_matrix[row][i] != 0)
                return i;
        end
        return n;
    endfunction

    function automatic rsp_t apply_graph_op(input req_t r);
        rsp_t o;
        int n;
        logic a_ok;
        logic b_ok;
        logic [WEIGHT_IN_BITS-1:0] stored;
        logic [WEIGHT_IN_BITS-1:0] next_w;
        o = '0;
        n = active_vertices();
        a_ok = r.from_vertex < n;
        b_ok = r.to_vertex < n;
        stored = weight_matrix[r.from_vertex][r.to_vertex];
        case (r.kind)
            OP_SET_EDGE, OP_DEL_EDGE, OP_TEST_EDGE:
            begin
                if (!a_ok || !b_ok)
                    o.bad_vertex = 1'b1;
                else if (r.kind == OP_TEST_EDGE)
                    o.edge_present = stored != 0;
                else
                begin
                    next_w = (r.kind == OP_SET_EDGE) ? r.weight : '0;
                    if (stored == 0 && next_w != 0)
                        edge_total++;
                    else if (stored != 0 && next_w == 0)
                        edge_total--;
                    weight_matrix[r.from_vertex][r.to_vertex] = next_w;
                end
            end
            OP_FIRST_NBR:
            begin
                if (!a_ok)
                begin
                    o.bad_vertex = 1'b1;
                    o.neighbor = NEIGHBOR_BITS'(n);
                end
                else
                    o.neighbor = NEIGHBOR_BITS'(scan_neighbours(int'(r.from_vertex), 0, n));
            end
            OP_NEXT_NBR:
            begin
                if (!a_ok || !b_ok)
                begin
                    o.bad_vertex = 1'b1;
                    o.neighbor = NEIGHBOR_BITS'(n);
                end
                else
                    o.neighbor = NEIGHBOR_BITS'(scan_neighbours(int'(r.from_vertex),
                        int'(r.to_vertex) + 1, n));
            end
            OP_READ_MARK:
            begin
                if (!a_ok)
                    o.bad_vertex = 1'b1;
                else
                    o.mark_out = vertex_marks[r.from_vertex];
            end
            OP_WRITE_MARK:
            begin
                if (!a_ok)
                    o.bad_vertex = 1'b1;
                else
                    vertex_marks[r.from_vertex] = r.mark_value;
            end
            default:
            begin
            end
        endcase
        o.edge_count = edge_total[COUNT_BITS-1:0];
        return o;
    endfunction

    task automatic send_request(input req_t r, input logic typed, input rsp_t want);
        int gap;
        rsp_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        predicted = apply_graph_op(r);
        pending_rsp.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [VCOUNT_BITS-1:0] value);
        drain_responses();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        vertex_count = value;
        cfg_writes++;
    endtask

    function automatic logic [VERTEX_BITS-1:0] pick_vertex();
        if ($urandom_range(0, 99) < 88)
            return VERTEX_BITS'($urandom_range(0, active_vertices() - 1));
        return VERTEX_BITS'($urandom_range(0, REACH_VERTICES - 1));
    endfunction

    function automatic logic [WEIGHT_IN_BITS-1:0] pick_weight();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        if (sel < 14)
            return 16'h8000;
        if (sel < 18)
            return 16'h7FFF;
        if (sel < 21)
            return 16'hFFFF;
        return WEIGHT_IN_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic req_t random_request();
        req_t r;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            r.kind = OP_SET_EDGE;
        else if (sel < 45)
            r.kind = OP_DEL_EDGE;
        else if (sel < 55)
            r.kind = OP_TEST_EDGE;
        else if (sel < 65)
            r.kind = OP_FIRST_NBR;
        else if (sel < 80)
            r.kind = OP_NEXT_NBR;
        else if (sel < 87)
            r.kind = OP_READ_MARK;
        else if (sel < 94)
            r.kind = OP_WRITE_MARK;
        else
            r.kind = OP_READ_COUNT;
        r.from_vertex = pick_vertex();
        r.to_vertex = pick_vertex();
        r.weight = pick_weight();
        r.mark_value = MARK_IN_BITS'($urandom_range(0, 255));
        return r;
    endfunction

    initial
    begin : rsp_side
        rsp_t want;
        int stall;
        wait (rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
            responses_seen++;
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding: %p", rsp);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.edge_present !== want.edge_present)
                begin
                    $error("edge_present: expected %0d, got %0d", want.edge_present,
                        rsp.edge_present);
                    errors++;
                end
                if (rsp.neighbor !== want.neighbor)
                begin
                    $error("neighbor: expected %0d, got %0d", want.neighbor, rsp.neighbor);
                    errors++;
                end
                if (rsp.mark_out !== want.mark_out)
                begin
                    $error("mark_out: expected %0d, got %0d", want.mark_out, rsp.mark_out);
                    errors++;
                end
                if (rsp.edge_count !== want.edge_count)
                begin
                    $error("edge_count: expected %0d, got %0d", want.edge_count,
                        rsp.edge_count);
                    errors++;
                end
                if (rsp.bad_vertex !== want.bad_vertex)
                begin
                    $error("bad_vertex: expected %0d, got %0d", want.bad_vertex,
                        rsp.bad_vertex);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("adjacency_matrix_graph_store_tb NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        req_t r;
        for (int a = 0; a < REACH_VERTICES; a++)
        begin
            vertex_marks[a] = '0;
            for (int b = 0; b < REACH_VERTICES; b++)
                weight_matrix[a][b] = '0;
        end
        edge_total = 0;
        vertex_count = VCOUNT_BITS'(VCOUNT_RESET);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].cfg_write)
                write_vertex_count(DIRECTED[i].cfg_value);
            else
                send_request(DIRECTED[i].r, DIRECTED[i].typed, DIRECTED[i].want);
        end

        // Fill every entry so that the edge count reaches the matrix size.
        write_vertex_count(5'd16);
        for (int a = 0; a < REACH_VERTICES; a++)
        begin
            for (int b = 0; b < REACH_VERTICES; b++)
            begin
                r.kind = OP_SET_EDGE;
                r.from_vertex = VERTEX_BITS'(a);
                r.to_vertex = VERTEX_BITS'(b);
                r.weight = pick_weight();
                if (r.weight == 0)
                    r.weight = 16'h0001;
                r.mark_value = MARK_IN_BITS'($urandom_range(0, 255));
                send_request(r, 1'b0, '0);
            end
        end
        r = '0;
        r.kind = OP_READ_COUNT;
        send_request(r, 1'b0, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            write_vertex_count(PHASE_VCOUNT[p]);
            no_idle = (p == 3);
            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                if (p == 5 && k == PHASE_REQUESTS / 2)
                    drain_responses();
                send_request(random_request(), 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        drain_responses();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests and %0d responses across %0d vertex count writes,",
            requests_sent, responses_seen, cfg_writes);
        $display("including counts of 0, 1, 16 and 31 and a completely filled matrix.");
        if (errors == 0)
            $display("adjacency_matrix_graph_store_tb OK");
        else
            $display("adjacency_matrix_graph_store_tb NOT OK");
        $finish;
    end

endmodule
